// ===== hw/rtl/hsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_pkg: shared types and constants of the 3x3 heat stencil
// Register indexes, reset values, field widths and the structs passed
// between the configuration block, the line/window stage and the MAC stage.
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int WGT_W      = 16;
  localparam int FLOOR_W    = 24;
  localparam int ROW_W      = 12;
  localparam int GEO_W      = 14;
  localparam int HEIGHT_MAX = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_WEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_WEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_FLOOR    = 3'd5;

  localparam logic [FW_W-1:0]           FRAME_WIDTH_RST   = 11'd1024;
  localparam logic [FH_W-1:0]           FRAME_HEIGHT_RST  = 13'd1024;
  localparam logic [WGT_W-1:0]          CORNER_WEIGHT_RST = 16'd3277;
  localparam logic [WGT_W-1:0]          EDGE_WEIGHT_RST   = 16'd6554;
  localparam logic [WGT_W-1:0]          CENTER_WEIGHT_RST = 16'd26214;
  localparam logic signed [FLOOR_W-1:0] PEAK_FLOOR_RST    = 24'sd7680;

  typedef struct packed {
    logic [FW_W-1:0]           frame_width;
    logic [FH_W-1:0]           frame_height;
    logic [WGT_W-1:0]          corner_weight;
    logic [WGT_W-1:0]          edge_weight;
    logic [WGT_W-1:0]          center_weight;
    logic signed [FLOOR_W-1:0] peak_floor;
  } cfg_t;

  typedef struct packed {
    logic                      last;
    logic                      use_floor;
    logic signed [FLOOR_W-1:0] floor_val;
  } meta_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_if: stream channels of the 3x3 heat stencil
// Sample input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hsp_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface hsp_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] new_value;
  logic signed [SAMPLE_BITS-1:0] peak;
  logic                          last;

  modport source (output valid, output new_value, output peak, output last, input ready);
  modport sink   (input valid, input new_value, input peak, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hsp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hsp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/hsp_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_cfg: configuration registers
// Frame geometry, stencil weights and peak floor, written by index.
// ----------------------------------------------------------------------------
module hsp_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [hsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output      hsp_pkg::cfg_t                   cfg
);
  import hsp_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= FRAME_WIDTH_RST;
      cfg_r.frame_height  <= FRAME_HEIGHT_RST;
      cfg_r.corner_weight <= CORNER_WEIGHT_RST;
      cfg_r.edge_weight   <= EDGE_WEIGHT_RST;
      cfg_r.center_weight <= CENTER_WEIGHT_RST;
      cfg_r.peak_floor    <= PEAK_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   cfg_r.frame_width   <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT:  cfg_r.frame_height  <= cfg_wdata[FH_W-1:0];
        REG_CORNER_WEIGHT: cfg_r.corner_weight <= cfg_wdata[WGT_W-1:0];
        REG_EDGE_WEIGHT:   cfg_r.edge_weight   <= cfg_wdata[WGT_W-1:0];
        REG_CENTER_WEIGHT: cfg_r.center_weight <= cfg_wdata[WGT_W-1:0];
        REG_PEAK_FLOOR:    cfg_r.peak_floor    <= $signed(cfg_wdata[FLOOR_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hw/rtl/hsp_line_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_line_window: raster counters, line buffers and 3x3 window
// Tracks row and column, reads both line buffers on accept, rotates them
// and shifts the window as each word leaves the first stage.
// ----------------------------------------------------------------------------
module hsp_line_window #(
  parameter int MAX_ROW     = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire hsp_pkg::cfg_t                     cfg,
  hsp_in_if.sink                                 in_ch,
  output      logic                              win_valid,
  input  wire logic                              win_ready,
  output      logic [8:0][SAMPLE_BITS-1:0]       win,
  output      hsp_pkg::meta_t                    win_meta
);
  import hsp_pkg::*;

  localparam int CW = $clog2(MAX_ROW);
  localparam logic [GEO_W-1:0] W_MAX = GEO_W'(MAX_ROW);
  localparam logic [GEO_W-1:0] H_MAX = GEO_W'(HEIGHT_MAX);
  localparam logic [GEO_W-1:0] G_MIN = GEO_W'(3);
  localparam logic [GEO_W-1:0] G_TWO = GEO_W'(2);

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             flr_pend_r;
  logic signed [FLOOR_W-1:0] flr_cap_r;

  logic [GEO_W-1:0] fw_ext, fh_ext, w_eff, h_eff, w_last, h_last, col_ext, row_ext;
  logic             col_end, row_end, emit_now, last_now, start_now;
  logic             accept, adv1, rdy1, rdy2;

  logic                   v1_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [CW-1:0]          s1_col_r;
  logic                   s1_emit_r;
  meta_t                  s1_meta_r;

  logic                   v2_r;
  meta_t                  s2_meta_r;
  logic [8:0][SAMPLE_BITS-1:0] win_r;

  logic [SAMPLE_BITS-1:0] top_rd, mid_rd;

  assign fw_ext  = GEO_W'(cfg.frame_width);
  assign fh_ext  = GEO_W'(cfg.frame_height);
  assign w_eff   = (fw_ext < G_MIN) ? G_MIN : ((fw_ext > W_MAX) ? W_MAX : fw_ext);
  assign h_eff   = (fh_ext < G_MIN) ? G_MIN : ((fh_ext > H_MAX) ? H_MAX : fh_ext);
  assign w_last  = w_eff - GEO_W'(1);
  assign h_last  = h_eff - GEO_W'(1);
  assign col_ext = GEO_W'(col_r);
  assign row_ext = GEO_W'(row_r);

  assign col_end   = col_ext >= w_last;
  assign row_end   = row_ext >= h_last;
  assign emit_now  = (row_ext >= G_TWO) && (col_ext >= G_TWO);
  assign last_now  = row_end && col_end;
  assign start_now = (row_r == '0) && (col_r == '0);

  assign rdy2   = !v2_r || win_ready;
  assign adv1   = v1_r && rdy2;
  assign rdy1   = !v1_r || adv1;
  assign accept = in_ch.valid && rdy1;
  assign in_ch.ready = rdy1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : ROW_W'(row_r + 1'b1);
    end else begin
      col_nxt = CW'(col_r + 1'b1);
    end
  end

  // raster position and frame-start floor capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      flr_pend_r <= 1'b1;
      flr_cap_r  <= PEAK_FLOOR_RST;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (start_now) begin
        flr_pend_r <= 1'b1;
        flr_cap_r  <= cfg.peak_floor;
      end else if (emit_now) begin
        flr_pend_r <= 1'b0;
      end
    end
  end

  // stage 1: line buffer read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (accept) begin
      v1_r <= 1'b1;
    end else if (adv1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r         <= in_ch.sample;
      s1_col_r            <= col_r;
      s1_emit_r           <= emit_now;
      s1_meta_r.last      <= last_now;
      s1_meta_r.use_floor <= flr_pend_r;
      s1_meta_r.floor_val <= flr_cap_r;
    end
  end

  hsp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_ROW)
  ) u_upper_ram (
    .clk     (clk),
    .wr_en   (adv1),
    .wr_addr (s1_col_r),
    .wr_data (mid_rd),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (top_rd)
  );

  hsp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_ROW)
  ) u_middle_ram (
    .clk     (clk),
    .wr_en   (adv1),
    .wr_addr (s1_col_r),
    .wr_data (s1_sample_r),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (mid_rd)
  );

  // stage 2: window, valid only for interior cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r  <= 1'b0;
      win_r <= '0;
    end else begin
      if (adv1) begin
        v2_r     <= s1_emit_r;
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= top_rd;
        win_r[3] <= win_r[4];
        win_r[4] <= win_r[5];
        win_r[5] <= mid_rd;
        win_r[6] <= win_r[7];
        win_r[7] <= win_r[8];
        win_r[8] <= s1_sample_r;
      end else if (win_ready) begin
        v2_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_meta_r <= s1_meta_r;
    end
  end

  assign win_valid = v2_r;
  assign win       = win_r;
  assign win_meta  = s2_meta_r;

  a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (adv1 && accept) |-> (s1_col_r != col_r))
    else $error("line buffer read and write hit the same column");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_now) |=> (col_r == '0 && row_r == '0))
    else $error("raster position did not wrap after the last cell");

  a_emit_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit_now) |-> (col_r >= CW'(2) && row_r >= ROW_W'(2)))
    else $error("result raised on a border position");

endmodule
`default_nettype wire

// ===== hw/rtl/hsp_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_mac: weighted stencil sum, rounding, saturation and running peak
// Group sums, three weight products, then sum, round half up, shift by 16,
// saturate and update the frame peak into the output register.
// ----------------------------------------------------------------------------
module hsp_mac #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hsp_pkg::cfg_t                 cfg,
  input  wire logic                          win_valid,
  output      logic                          win_ready,
  input  wire logic [8:0][SAMPLE_BITS-1:0]   win,
  input  wire hsp_pkg::meta_t                win_meta,
  hsp_out_if.source                          out_ch
);
  import hsp_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int CS  = SB + 2;
  localparam int PRW = SB + 19;
  localparam int AW  = SB + 21;
  localparam int RW  = SB + 5;
  localparam int PW  = (SB > FLOOR_W) ? SB : FLOOR_W;

  localparam logic signed [AW-1:0] RND    = {{(AW-16){1'b0}}, 1'b1, 15'b0};
  localparam logic signed [RW-1:0] RES_HI = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [RW-1:0] RES_LO = {{(RW-SB+1){1'b1}}, {(SB-1){1'b0}}};
  localparam logic signed [PW-1:0] PK_HI  = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [PW-1:0] PK_LO  = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  logic rdy3, rdy4, rdy5;

  logic                 v3_r;
  logic signed [CS-1:0] corner3_r, edge3_r, center3_r;
  meta_t                meta3_r;

  logic                  v4_r;
  logic signed [PRW-1:0] pc4_r, pe4_r, pz4_r;
  meta_t                 meta4_r;

  logic                 out_valid_r;
  logic signed [SB-1:0] new_value_r, peak_out_r;
  logic                 last_r;
  logic signed [PW-1:0] peak_r;

  logic signed [CS-1:0] corner_sum, edge_sum;
  logic signed [AW-1:0] acc;
  logic signed [RW-1:0] shifted;
  logic signed [SB-1:0] nv;
  logic signed [PW-1:0] nv_ext, base, peak_nxt;
  logic signed [SB-1:0] peak_sat;

  assign rdy5      = !out_valid_r || out_ch.ready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign win_ready = rdy3;

  assign corner_sum = CS'($signed(win[0])) + CS'($signed(win[2]))
                    + CS'($signed(win[6])) + CS'($signed(win[8]));
  assign edge_sum   = CS'($signed(win[1])) + CS'($signed(win[3]))
                    + CS'($signed(win[5])) + CS'($signed(win[7]));

  // stage 3: group sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && win_valid) begin
      corner3_r <= corner_sum;
      edge3_r   <= edge_sum;
      center3_r <= CS'($signed(win[4]));
      meta3_r   <= win_meta;
    end
  end

  // stage 4: weight products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      pc4_r   <= PRW'($signed({1'b0, cfg.corner_weight})) * PRW'(corner3_r);
      pe4_r   <= PRW'($signed({1'b0, cfg.edge_weight}))   * PRW'(edge3_r);
      pz4_r   <= PRW'($signed({1'b0, cfg.center_weight})) * PRW'(center3_r);
      meta4_r <= meta3_r;
    end
  end

  // sum, round, saturate, peak
  assign acc     = AW'(pc4_r) + AW'(pe4_r) + AW'(pz4_r) + RND;
  assign shifted = acc[AW-1:16];
  assign nv      = (shifted > RES_HI) ? SB'(RES_HI) :
                   (shifted < RES_LO) ? SB'(RES_LO) : shifted[SB-1:0];

  assign nv_ext   = PW'(nv);
  assign base     = meta4_r.use_floor ? PW'(meta4_r.floor_val) : peak_r;
  assign peak_nxt = (nv_ext > base) ? nv_ext : base;
  assign peak_sat = (peak_nxt > PK_HI) ? SB'(PK_HI) :
                    (peak_nxt < PK_LO) ? SB'(PK_LO) : peak_nxt[SB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      peak_r      <= PW'(PEAK_FLOOR_RST);
    end else if (rdy5) begin
      out_valid_r <= v4_r;
      if (v4_r) begin
        peak_r <= peak_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      new_value_r <= nv;
      peak_out_r  <= peak_sat;
      last_r      <= meta4_r.last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.new_value = new_value_r;
  assign out_ch.peak      = peak_out_r;
  assign out_ch.last      = last_r;

  a_peak_covers_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (peak_out_r >= new_value_r))
    else $error("peak below the value it reports with");

  a_peak_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(peak_r))
    else $error("running peak moved while the output was stalled");

endmodule
`default_nettype wire

// ===== hw/rtl/heat_stencil_3x3_peak.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heat_stencil_3x3_peak: streaming 3x3 heat diffusion step with frame peak
// Takes a padded frame in row-major order, one sample word per clock unless
// stalled, and returns one word per tile cell: diffused value, running peak
// and a last flag on the final cell of the frame.
// ----------------------------------------------------------------------------
// Sustained rate is one sample word per clock unless stalled, with no gaps at
// frame or row boundaries; a result passes stage 1, window, sum, product and
// output registers after the sample closing its neighborhood. The rate is set
// by the two line buffers, each a RAM of MAX_ROW words read once when a sample
// is taken and written once when it leaves the first stage. No clearing pass
// runs after reset: the first two rows of each frame fill the line buffers
// before any result depends on them. Frame width is clamped to 3..MAX_ROW and
// height to 3..4096. Write configuration only while no words are in flight;
// a new peak floor takes effect at the next frame's first sample.
// ----------------------------------------------------------------------------
module heat_stencil_3x3_peak #(
  parameter int MAX_ROW     = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  hsp_in_if.sink                               in_ch,
  hsp_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [hsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import hsp_pkg::*;

  cfg_t                        cfg;
  logic                        win_valid;
  logic                        win_ready;
  logic [8:0][SAMPLE_BITS-1:0] win;
  meta_t                       win_meta;

  hsp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hsp_line_window #(
    .MAX_ROW     (MAX_ROW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .win_meta  (win_meta)
  );

  hsp_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .win_meta  (win_meta),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3x3 heat stencil with frame peak
// Streams padded frames through the block under random valid/ready pacing,
// predicts every tile cell (diffused value, running peak, last flag) from
// its own line buffers and window, and compares each result word in order.
// Covers saturation both ways, clamped and resized geometry, spare register
// indexes and a long output hold.
// ----------------------------------------------------------------------------
module tb_top;
  import hsp_pkg::*;

  localparam int SB           = 24;
  localparam int MAX_ROW      = 1024;
  localparam int SETTLE       = 16;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_ITEMS  = 560;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

  typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_EXTREME} spread_e;

  typedef struct packed {
    logic signed [SB-1:0] new_value;
    logic signed [SB-1:0] peak;
    logic                 last;
  } cell_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hsp_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  hsp_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  heat_stencil_3x3_peak #(
    .MAX_ROW     (MAX_ROW),
    .SAMPLE_BITS (SB)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: configuration copy, line buffers, window, raster position
  logic [FW_W-1:0]           frame_width_r  = FRAME_WIDTH_RST;
  logic [FH_W-1:0]           frame_height_r = FRAME_HEIGHT_RST;
  logic [WGT_W-1:0]          corner_w       = CORNER_WEIGHT_RST;
  logic [WGT_W-1:0]          edge_w         = EDGE_WEIGHT_RST;
  logic [WGT_W-1:0]          center_w       = CENTER_WEIGHT_RST;
  logic signed [FLOOR_W-1:0] floor_r        = PEAK_FLOOR_RST;

  logic signed [SB-1:0] upper_line  [MAX_ROW] = '{default: '0};
  logic signed [SB-1:0] middle_line [MAX_ROW] = '{default: '0};
  logic signed [SB-1:0] win [3][3]            = '{default: '0};
  logic signed [SB-1:0] run_peak              = PEAK_FLOOR_RST;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  logic signed [SB-1:0] sample_q [$];
  cell_t                cell_q [$];

  int unsigned gen_row = 0;
  int unsigned gen_col = 0;
  int unsigned pushed_count = 0;
  int unsigned accepted_count = 0;
  int unsigned results_seen = 0;
  int unsigned frames_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned err_count = 0;
  int unsigned hold_req = 0;
  int unsigned hold_served = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  function automatic int unsigned cols_used();
    if (frame_width_r < 3) return 3;
    if (frame_width_r > MAX_ROW) return MAX_ROW;
    return 32'(frame_width_r);
  endfunction

  function automatic int unsigned rows_used();
    if (frame_height_r < 3) return 3;
    if (frame_height_r > HEIGHT_MAX) return HEIGHT_MAX;
    return 32'(frame_height_r);
  endfunction

  task automatic advance_pos(inout int unsigned r, inout int unsigned c);
    if (c >= cols_used() - 1) begin
      c = 0;
      r = (r >= rows_used() - 1) ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
  endtask

  task automatic diffuse_sample(input logic signed [SB-1:0] s);
    logic signed [SB-1:0] top;
    logic signed [SB-1:0] mid;
    longint corners;
    longint sides;
    longint acc;
    longint nv;
    cell_t  item;
    if (row_pos == 0 && col_pos == 0) run_peak = floor_r;
    top = upper_line[col_pos];
    mid = middle_line[col_pos];
    upper_line[col_pos]  = mid;
    middle_line[col_pos] = s;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = s;
    if (row_pos >= 2 && col_pos >= 2) begin
      corners = longint'(win[0][0]) + longint'(win[0][2])
              + longint'(win[2][0]) + longint'(win[2][2]);
      sides   = longint'(win[0][1]) + longint'(win[1][0])
              + longint'(win[1][2]) + longint'(win[2][1]);
      acc = longint'(corner_w) * corners + longint'(edge_w) * sides
          + longint'(center_w) * longint'(win[1][1]);
      nv = (acc + 64'sd32768) >>> 16;
      if (nv > longint'(SAMPLE_MAX)) nv = longint'(SAMPLE_MAX);
      else if (nv < longint'(SAMPLE_MIN)) nv = longint'(SAMPLE_MIN);
      if (nv > longint'(run_peak)) run_peak = nv[SB-1:0];
      item.new_value = nv[SB-1:0];
      item.peak      = run_peak;
      item.last      = (row_pos >= rows_used() - 1) && (col_pos >= cols_used() - 1);
      cell_q = {cell_q, item};
    end
    advance_pos(row_pos, col_pos);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    reg_writes++;
    case (idx)
      REG_FRAME_WIDTH:   frame_width_r  = val[FW_W-1:0];
      REG_FRAME_HEIGHT:  frame_height_r = val[FH_W-1:0];
      REG_CORNER_WEIGHT: corner_w       = val[WGT_W-1:0];
      REG_EDGE_WEIGHT:   edge_w         = val[WGT_W-1:0];
      REG_CENTER_WEIGHT: center_w       = val[WGT_W-1:0];
      REG_PEAK_FLOOR:    floor_r        = val[FLOOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(input logic signed [SB-1:0] s);
    sample_q = {sample_q, s};
    pushed_count++;
    advance_pos(gen_row, gen_col);
    if (gen_row == 0 && gen_col == 0) frames_sent++;
  endtask

  function automatic logic signed [SB-1:0] pick_sample(input spread_e spread);
    case (spread)
      SPREAD_NARROW: return SB'($urandom_range(0, 131071) - 65536);
      SPREAD_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return SB'($urandom);
        endcase
      end
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic finish_frame(input spread_e spread);
    do push_sample(pick_sample(spread)); while (gen_row != 0 || gen_col != 0);
  endtask

  // Wait until every pushed word is taken and every predicted cell has come back
  task automatic wait_idle();
    do @(posedge clk); while (accepted_count != pushed_count || cell_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_weights(input bit wild);
    if (wild) begin
      set_reg(REG_CORNER_WEIGHT, ($urandom << WGT_W) | $urandom_range(0, 65535));
      set_reg(REG_EDGE_WEIGHT,   ($urandom << WGT_W) | $urandom_range(0, 65535));
      set_reg(REG_CENTER_WEIGHT, ($urandom << WGT_W) | $urandom_range(0, 65535));
    end else begin
      set_reg(REG_CORNER_WEIGHT, $urandom_range(0, 4096));
      set_reg(REG_EDGE_WEIGHT,   $urandom_range(0, 8192));
      set_reg(REG_CENTER_WEIGHT, $urandom_range(0, 32768));
    end
    if ($urandom_range(0, 1) == 0) set_reg(REG_PEAK_FLOOR, $urandom_range(0, 4000) - 2000);
    else set_reg(REG_PEAK_FLOOR, $urandom);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycle_count);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= '0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        diffuse_sample(in_ch.sample);
        accepted_count++;
        if (!quiet && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 19);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_ch.valid  <= 1'b1;
          in_ch.sample <= sample_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    cell_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      hold_served = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cell_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("tb_top: unexpected result new_value %0d peak %0d last %0b",
                     out_ch.new_value, out_ch.peak, out_ch.last);
        end else begin
          want = cell_q.pop_front();
          results_seen++;
          if (out_ch.new_value !== want.new_value || out_ch.peak !== want.peak ||
              out_ch.last !== want.last) begin
            err_count++;
            if (err_count <= 10)
              $display("tb_top: result %0d expected %0d/%0d/%0b got %0d/%0d/%0b",
                       results_seen, want.new_value, want.peak, want.last,
                       out_ch.new_value, out_ch.peak, out_ch.last);
          end
        end
      end
      if (hold_served != hold_req) begin
        hold_served++;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned rand_items;
    int unsigned start_count;
    int unsigned n_frames;
    spread_e     spread;
    bit          wild;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    phase        = 0;
    rand_items   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame, all weights full scale: drive high saturation
    set_reg(REG_FRAME_WIDTH, 3);
    set_reg(REG_FRAME_HEIGHT, 3);
    set_reg(REG_CORNER_WEIGHT, 32'hFFFF);
    set_reg(REG_EDGE_WEIGHT, 32'hFFFF);
    set_reg(REG_CENTER_WEIGHT, 32'hFFFF);
    set_reg(REG_PEAK_FLOOR, 32'(SAMPLE_MIN));
    set_reg(REG_SPARE_LO, $urandom);
    set_reg(REG_SPARE_HI, $urandom);
    end_writes();
    repeat (9) push_sample(SAMPLE_MAX);
    wait_idle();

    // Low saturation while the peak holds at the top floor
    set_reg(REG_PEAK_FLOOR, 32'(SAMPLE_MAX));
    end_writes();
    repeat (9) push_sample(SAMPLE_MIN);
    wait_idle();

    // Shrink geometry and move the floor in the middle of a frame
    set_reg(REG_FRAME_WIDTH, ($urandom << FW_W) | 5);
    set_reg(REG_FRAME_HEIGHT, 5);
    set_reg(REG_CORNER_WEIGHT, 32'(CORNER_WEIGHT_RST));
    set_reg(REG_EDGE_WEIGHT, 32'(EDGE_WEIGHT_RST));
    set_reg(REG_CENTER_WEIGHT, 32'(CENTER_WEIGHT_RST));
    set_reg(REG_PEAK_FLOOR, 32'(PEAK_FLOOR_RST));
    end_writes();
    repeat (13) push_sample(pick_sample(SPREAD_NARROW));
    wait_idle();
    set_reg(REG_FRAME_WIDTH, 0);
    set_reg(REG_FRAME_HEIGHT, 0);
    set_reg(REG_PEAK_FLOOR, $urandom);
    end_writes();
    finish_frame(SPREAD_NARROW);
    wait_idle();

    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= QUIET_ITEMS) quiet = 1'b1;
      wild   = ($urandom_range(0, 2) == 0);
      spread = spread_e'($urandom_range(0, 2));
      n_frames = $urandom_range(1, 3);
      if (phase == 1) begin
        set_reg(REG_FRAME_WIDTH, 32);
        set_reg(REG_FRAME_HEIGHT, 12);
        n_frames = 1;
      end else begin
        if ($urandom_range(0, 7) == 0)
          set_reg(REG_FRAME_WIDTH, ($urandom << FW_W) | $urandom_range(0, 2));
        else
          set_reg(REG_FRAME_WIDTH, ($urandom << FW_W) | $urandom_range(3, 14));
        if ($urandom_range(0, 7) == 0)
          set_reg(REG_FRAME_HEIGHT, ($urandom << FH_W) | $urandom_range(0, 2));
        else
          set_reg(REG_FRAME_HEIGHT, ($urandom << FH_W) | $urandom_range(3, 7));
      end
      random_weights(wild);
      end_writes();
      // hold the result side long enough to back up the input
      if (phase == 1) hold_req++;
      start_count = pushed_count;
      repeat (n_frames) finish_frame(spread);
      rand_items += pushed_count - start_count;
      wait_idle();
      phase++;
    end

    wait_idle();
    err_count += cell_q.size();
    $display("tb_top: %0d samples in %0d frames, %0d cells checked, %0d register writes",
             pushed_count, frames_sent, results_seen, reg_writes);
    $display("tb_top: saturation, clamped and resized geometry, long output hold; %0d errors",
             err_count);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hsp_pkg.sv
hw/rtl/hsp_if.sv
hw/rtl/hsp_ram.sv
hw/rtl/hsp_cfg.sv
hw/rtl/hsp_line_window.sv
hw/rtl/hsp_mac.sv
hw/rtl/heat_stencil_3x3_peak.sv
tb/tb_top.sv
